// ===== rtl/core/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared widths, record codes and handshake structs of the SRTF schedule core.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int unsigned ArrW    = 16;
  localparam int unsigned TimeW   = 21;
  localparam int unsigned TatW    = 20;
  localparam int unsigned SumW    = 24;
  localparam int unsigned CntW    = 5;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned InW     = 32;
  localparam int unsigned OutW    = 120;

  localparam logic KindProc  = 1'b0;
  localparam logic KindTotal = 1'b1;

  typedef struct packed {
    logic [ArrW-1:0] rem;
    logic [ArrW-1:0] arr;
    logic [ArrW-1:0] bur;
  } entry_t;

  typedef struct packed {
    logic             clear;
    logic             en;
    logic [TimeW-1:0] sim_time;
  } sel_ctl_t;

  typedef struct packed {
    logic            have_best;
    logic [ArrW-1:0] best_rem;
    logic [ArrW-1:0] best_arr;
    logic [ArrW-1:0] best_bur;
    logic            have_next;
    logic [ArrW-1:0] next_arr;
  } sel_res_t;

endpackage

// ===== rtl/core/srtf_ptab.sv =====
// ----------------------------------------------------------------------------
// srtf_ptab
// Process table: arrival, burst and remaining time per entry, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module srtf_ptab #(
  parameter int unsigned NPROC = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic                   wr_full_i,
  input  logic [IW-1:0]          wr_addr_i,
  input  srtf_pkg::entry_t       wr_data_i,
  input  logic [IW-1:0]          rd_addr_i,
  output srtf_pkg::entry_t       rd_data_o
);

  logic [srtf_pkg::ArrW-1:0] rem_mem [NPROC];
  logic [srtf_pkg::ArrW-1:0] arr_mem [NPROC];
  logic [srtf_pkg::ArrW-1:0] bur_mem [NPROC];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rem_mem[wr_addr_i] <= wr_data_i.rem;
      if (wr_full_i) begin
        arr_mem[wr_addr_i] <= wr_data_i.arr;
        bur_mem[wr_addr_i] <= wr_data_i.bur;
      end
    end
    rd_data_o.rem <= rem_mem[rd_addr_i];
    rd_data_o.arr <= arr_mem[rd_addr_i];
    rd_data_o.bur <= bur_mem[rd_addr_i];
  end

endmodule

// ===== rtl/core/srtf_sel.sv =====
// ----------------------------------------------------------------------------
// srtf_sel
// Shared compare unit: folds one table entry a cycle into the running choice
// of least remaining time among arrived entries and earliest pending arrival.
// ----------------------------------------------------------------------------
module srtf_sel #(
  parameter int unsigned IW = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srtf_pkg::sel_ctl_t ctl_i,
  input  srtf_pkg::entry_t   ent_i,
  input  logic [IW-1:0]      idx_i,
  output srtf_pkg::sel_res_t res_o,
  output logic [IW-1:0]      best_idx_o
);

  logic                      have_best_q;
  logic                      have_next_q;
  logic [srtf_pkg::ArrW-1:0] best_rem_q;
  logic [srtf_pkg::ArrW-1:0] best_arr_q;
  logic [srtf_pkg::ArrW-1:0] best_bur_q;
  logic [srtf_pkg::ArrW-1:0] next_arr_q;
  logic [IW-1:0]             best_idx_q;
  logic                      live;
  logic                      arrived;
  logic                      take_best;
  logic                      take_next;

  assign live      = ent_i.rem != '0;
  assign arrived   = {{(srtf_pkg::TimeW-srtf_pkg::ArrW){1'b0}}, ent_i.arr} <= ctl_i.sim_time;
  assign take_best = ctl_i.en && live && arrived
                     && (!have_best_q || ent_i.rem < best_rem_q);
  assign take_next = ctl_i.en && live && !arrived
                     && (!have_next_q || ent_i.arr < next_arr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      have_next_q <= 1'b0;
    end else if (ctl_i.clear) begin
      have_best_q <= 1'b0;
      have_next_q <= 1'b0;
    end else begin
      if (take_best) have_best_q <= 1'b1;
      if (take_next) have_next_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_rem_q <= ent_i.rem;
      best_arr_q <= ent_i.arr;
      best_bur_q <= ent_i.bur;
      best_idx_q <= idx_i;
    end
    if (take_next) begin
      next_arr_q <= ent_i.arr;
    end
  end

  assign res_o      = '{have_best: have_best_q, best_rem: best_rem_q, best_arr: best_arr_q,
                        best_bur: best_bur_q, have_next: have_next_q, next_arr: next_arr_q};
  assign best_idx_o = best_idx_q;

endmodule

// ===== rtl/core/srtf_preemptive_schedule_core.sv =====
// ----------------------------------------------------------------------------
// srtf_preemptive_schedule_core
// Preemptive shortest-remaining-time-first scheduler over a loaded process set.
// ----------------------------------------------------------------------------
// Load beats (arrival, burst) are taken in StLoad; the beat with tlast closes
// the set and starts the run, during which no input beat is accepted. The run
// moves from decision point to decision point: each one scans the process
// table through its single read port, one entry a cycle, into a shared
// compare unit; a wait state and a decide state that picks the run length
// follow, then an exec state applies it and, on a completion, a turnaround
// state and an emit state form and post the completion beat. A totals beat
// closes the run. The core stalls whenever the output register still holds
// an untaken beat. Loads beyond NPROC are dropped and flag overflow on every
// result beat.
module srtf_preemptive_schedule_core #(
  parameter int unsigned NPROC = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [srtf_pkg::InW-1:0]    s_axis_tdata_i,  // arrival, burst
  input  logic                        s_axis_tlast_i,  // last_process
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [srtf_pkg::OutW-1:0]   m_axis_tdata_o,  // proc_index, finish_time,
                                                       // turnaround, waiting,
                                                       // total_turnaround,
                                                       // total_waiting,
                                                       // process_count, overflow
  output logic                        m_axis_tuser_o,  // kind
  output logic                        m_axis_tlast_o   // last_result
);

  localparam int unsigned IW = (NPROC > 1) ? $clog2(NPROC) : 1;
  localparam int unsigned CW = $clog2(NPROC + 1);

  typedef enum logic [2:0] {
    StLoad, StScan, StWait, StDecide, StExec, StTatw, StEmit, StTotal
  } state_e;

  state_e                     state_q;
  logic [CW-1:0]              loaded_q;
  logic [CW-1:0]              done_q;
  logic [IW-1:0]              scan_idx_q;
  logic [IW-1:0]              rd_idx_q;
  logic                       rd_vld_q;
  logic [srtf_pkg::TimeW-1:0] time_q;
  logic [srtf_pkg::SumW-1:0]  sum_tat_q;
  logic [srtf_pkg::SumW-1:0]  sum_wt_q;
  logic                       ovf_q;
  logic [srtf_pkg::ArrW-1:0]  run_q;
  logic [srtf_pkg::TatW-1:0]  tat_q;

  logic                         out_vld_q;
  logic                         out_kind_q;
  logic [srtf_pkg::IdxOutW-1:0] out_idx_q;
  logic [srtf_pkg::TimeW-1:0]   out_fin_q;
  logic [srtf_pkg::TatW-1:0]    out_tat_q;
  logic [srtf_pkg::TatW-1:0]    out_wt_q;
  logic [srtf_pkg::SumW-1:0]    out_ttat_q;
  logic [srtf_pkg::SumW-1:0]    out_twt_q;
  logic [srtf_pkg::CntW-1:0]    out_cnt_q;
  logic                         out_ovf_q;
  logic                         out_last_q;

  logic                       in_fire;
  logic                       out_free;
  logic                       out_load;
  logic                       set_full;
  logic                       scan_last;
  logic [srtf_pkg::ArrW-1:0]  in_arr;
  logic [srtf_pkg::ArrW-1:0]  in_bur;
  logic [srtf_pkg::TimeW-1:0] gap;
  logic [srtf_pkg::ArrW-1:0]  new_rem;
  logic [srtf_pkg::TatW-1:0]  wt;
  logic [CW-1:0]              loaded_nx;

  logic                       wr_en;
  logic                       wr_full;
  logic [IW-1:0]              wr_addr;
  srtf_pkg::entry_t           wr_data;
  srtf_pkg::entry_t           rd_data;
  srtf_pkg::sel_ctl_t         sel_ctl;
  srtf_pkg::sel_res_t         sel_res;
  logic [IW-1:0]              best_idx;

  assign s_axis_tready_o = state_q == StLoad;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_vld_q || m_axis_tready_i;
  assign out_load  = ((state_q == StEmit) || (state_q == StTotal)) && out_free;
  assign set_full  = loaded_q == CW'(NPROC);
  assign loaded_nx = set_full ? loaded_q : loaded_q + CW'(1);
  assign scan_last = (CW'(scan_idx_q) + CW'(1)) == loaded_q;
  assign in_arr    = s_axis_tdata_i[15:0];
  assign in_bur    = (s_axis_tdata_i[31:16] == '0) ? 16'd1 : s_axis_tdata_i[31:16];
  assign gap       = {{(srtf_pkg::TimeW-srtf_pkg::ArrW){1'b0}}, sel_res.next_arr} - time_q;
  assign new_rem   = sel_res.best_rem - run_q;
  assign wt        = tat_q - {{(srtf_pkg::TatW-srtf_pkg::ArrW){1'b0}}, sel_res.best_bur};

  always_comb begin
    wr_en   = 1'b0;
    wr_full = 1'b0;
    wr_addr = loaded_q[IW-1:0];
    wr_data = '{rem: in_bur, arr: in_arr, bur: in_bur};
    if (in_fire && !set_full) begin
      wr_en   = 1'b1;
      wr_full = 1'b1;
    end else if (state_q == StExec) begin
      wr_en       = 1'b1;
      wr_addr     = best_idx;
      wr_data.rem = new_rem;
    end
  end

  assign sel_ctl = '{clear: (state_q == StScan) && (scan_idx_q == '0), en: rd_vld_q,
                     sim_time: time_q};

  srtf_ptab #(.NPROC(NPROC), .IW(IW)) u_ptab (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_full_i (wr_full),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (scan_idx_q),
    .rd_data_o (rd_data)
  );

  srtf_sel #(.IW(IW)) u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sel_ctl),
    .ent_i      (rd_data),
    .idx_i      (rd_idx_q),
    .res_o      (sel_res),
    .best_idx_o (best_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      loaded_q   <= '0;
      done_q     <= '0;
      scan_idx_q <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      time_q     <= '0;
      sum_tat_q  <= '0;
      sum_wt_q   <= '0;
      ovf_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= state_q == StScan;
      rd_idx_q <= scan_idx_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StLoad: begin
          if (in_fire) begin
            loaded_q <= loaded_nx;
            if (set_full) ovf_q <= 1'b1;
            if (s_axis_tlast_i) begin
              scan_idx_q <= '0;
              state_q    <= (loaded_nx == '0) ? StTotal : StScan;
            end
          end
        end
        StScan: begin
          if (scan_last) begin
            state_q <= StWait;
          end else begin
            scan_idx_q <= scan_idx_q + IW'(1);
          end
        end
        StWait: state_q <= StDecide;
        StDecide: begin
          if (!sel_res.have_best) begin
            time_q     <= {{(srtf_pkg::TimeW-srtf_pkg::ArrW){1'b0}}, sel_res.next_arr};
            scan_idx_q <= '0;
            state_q    <= StScan;
          end else begin
            run_q   <= (sel_res.have_next && gap < {5'd0, sel_res.best_rem})
                       ? gap[srtf_pkg::ArrW-1:0] : sel_res.best_rem;
            state_q <= StExec;
          end
        end
        StExec: begin
          time_q <= time_q + {{(srtf_pkg::TimeW-srtf_pkg::ArrW){1'b0}}, run_q};
          if (new_rem == '0) begin
            state_q <= StTatw;
          end else begin
            scan_idx_q <= '0;
            state_q    <= StScan;
          end
        end
        StTatw: begin
          tat_q   <= srtf_pkg::TatW'(time_q - {5'd0, sel_res.best_arr});
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_kind_q <= srtf_pkg::KindProc;
            out_idx_q  <= srtf_pkg::IdxOutW'(best_idx);
            out_fin_q  <= time_q;
            out_tat_q  <= tat_q;
            out_wt_q   <= wt;
            out_ttat_q <= '0;
            out_twt_q  <= '0;
            out_cnt_q  <= '0;
            out_ovf_q  <= ovf_q;
            out_last_q <= 1'b0;
            sum_tat_q  <= sum_tat_q + {4'd0, tat_q};
            sum_wt_q   <= sum_wt_q + {4'd0, wt};
            done_q     <= done_q + CW'(1);
            scan_idx_q <= '0;
            state_q    <= ((done_q + CW'(1)) == loaded_q) ? StTotal : StScan;
          end
        end
        StTotal: begin
          if (out_free) begin
            out_kind_q <= srtf_pkg::KindTotal;
            out_idx_q  <= '0;
            out_fin_q  <= time_q;
            out_tat_q  <= '0;
            out_wt_q   <= '0;
            out_ttat_q <= sum_tat_q;
            out_twt_q  <= sum_wt_q;
            out_cnt_q  <= srtf_pkg::CntW'(loaded_q);
            out_ovf_q  <= ovf_q;
            out_last_q <= 1'b1;
            loaded_q   <= '0;
            done_q     <= '0;
            time_q     <= '0;
            sum_tat_q  <= '0;
            sum_wt_q   <= '0;
            ovf_q      <= 1'b0;
            state_q    <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_ovf_q, out_cnt_q, out_twt_q, out_ttat_q,
                            out_wt_q, out_tat_q, out_fin_q, out_idx_q};

`ifndef SYNTH
  a_loaded_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= CW'(NPROC))
    else $error("loaded count beyond table depth");

  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= loaded_q)
    else $error("more completions than loaded processes");

  a_tat_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == srtf_pkg::KindProc)) |-> (out_tat_q != '0))
    else $error("completion beat with zero turnaround");

  a_run_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |-> (sel_res.have_best && run_q != '0))
    else $error("run step without a selected process");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of srtf_preemptive_schedule_core. Streams process sets into the
// core, predicts every completion and totals beat with a shortest-remaining-
// time-first schedule kept inside the bench, and checks the output stream in
// order, field by field. Both stream sides idle at random outside the back-to-back test.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ArrW    = srtf_pkg::ArrW;
  localparam int unsigned TimeW   = srtf_pkg::TimeW;
  localparam int unsigned TatW    = srtf_pkg::TatW;
  localparam int unsigned SumW    = srtf_pkg::SumW;
  localparam int unsigned CntW    = srtf_pkg::CntW;
  localparam int unsigned IdxOutW = srtf_pkg::IdxOutW;
  localparam int unsigned InW     = srtf_pkg::InW;
  localparam int unsigned OutW    = srtf_pkg::OutW;
  localparam logic KindProc       = srtf_pkg::KindProc;
  localparam logic KindTotal      = srtf_pkg::KindTotal;

  localparam int unsigned NProc      = 16;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemGoal   = 400;
  localparam int unsigned IdlePct    = 23;

  typedef struct {
    logic               kind;
    logic [IdxOutW-1:0] idx;
    logic [TimeW-1:0]   fin;
    logic [TatW-1:0]    tat;
    logic [TatW-1:0]    wt;
    logic [SumW-1:0]    sum_tat;
    logic [SumW-1:0]    sum_wt;
    logic [CntW-1:0]    count;
    logic               ovf;
    logic               last;
  } sched_rec_t;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [InW-1:0]  s_axis_tdata_i  = '0;  // arrival, burst
  logic            s_axis_tlast_i  = 1'b0; // last_process
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;        // proc_index, finish_time, turnaround,
                                          // waiting, total_turnaround,
                                          // total_waiting, process_count, overflow
  logic            m_axis_tuser_o;        // kind
  logic            m_axis_tlast_o;        // last_result

  // schedule state mirrored by the bench
  logic [ArrW-1:0] arr_tab [NProc];
  logic [ArrW-1:0] bur_tab [NProc];
  logic [ArrW-1:0] rem_tab [NProc];
  int unsigned     tab_count  = 0;
  int unsigned     done_count = 0;
  int unsigned     now        = 0;
  int unsigned     sum_tat    = 0;
  int unsigned     sum_wt     = 0;
  logic            ovf_seen   = 1'b0;

  sched_rec_t  due_records[$];
  int unsigned errors     = 0;
  int unsigned cycles     = 0;
  int unsigned items_sent = 0;
  bit          no_stall   = 1'b0;

  srtf_preemptive_schedule_core #(
    .NPROC(NProc)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic sched_rec_t make_record(input logic kind, input int unsigned idx,
                                             input int unsigned tat, input int unsigned wt,
                                             input int unsigned cnt);
    sched_rec_t rec;
    rec.kind    = kind;
    rec.idx     = idx[IdxOutW-1:0];
    rec.fin     = now[TimeW-1:0];
    rec.tat     = tat[TatW-1:0];
    rec.wt      = wt[TatW-1:0];
    rec.sum_tat = (kind == KindTotal) ? sum_tat[SumW-1:0] : '0;
    rec.sum_wt  = (kind == KindTotal) ? sum_wt[SumW-1:0] : '0;
    rec.count   = cnt[CntW-1:0];
    rec.ovf     = ovf_seen;
    rec.last    = (kind == KindTotal);
    return rec;
  endfunction

  // load one process; on the closing beat run the whole schedule
  function automatic void srtf_load_and_run(input logic [ArrW-1:0] arr,
                                            input logic [ArrW-1:0] bur, input logic last);
    int          best;
    int unsigned i;
    int unsigned next_arr;
    int unsigned run;
    int unsigned tat_v;
    int unsigned wt_v;
    bit          have_next;
    if (tab_count < NProc) begin
      arr_tab[tab_count] = arr;
      bur_tab[tab_count] = (bur == '0) ? 16'd1 : bur;
      rem_tab[tab_count] = (bur == '0) ? 16'd1 : bur;
      tab_count++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!last) return;
    while (done_count < tab_count) begin
      best      = -1;
      have_next = 1'b0;
      next_arr  = 0;
      for (i = 0; i < tab_count; i++) begin
        if (rem_tab[i] == '0) continue;
        if (arr_tab[i] <= now) begin
          if (best < 0 || rem_tab[i] < rem_tab[best]) best = int'(i);
        end else if (!have_next || arr_tab[i] < next_arr) begin
          next_arr  = 32'(arr_tab[i]);
          have_next = 1'b1;
        end
      end
      if (best < 0) begin
        now = next_arr;
        continue;
      end
      run = 32'(rem_tab[best]);
      if (have_next && next_arr - now < run) run = next_arr - now;
      rem_tab[best] = ArrW'(rem_tab[best] - run);
      now += run;
      if (rem_tab[best] == '0) begin
        tat_v = now - arr_tab[best];
        wt_v  = tat_v - bur_tab[best];
        done_count++;
        sum_tat = (sum_tat + tat_v) & 32'hFF_FFFF;
        sum_wt  = (sum_wt + wt_v) & 32'hFF_FFFF;
        due_records.push_back(make_record(KindProc, best, tat_v, wt_v, 0));
      end
    end
    due_records.push_back(make_record(KindTotal, 0, 0, 0, tab_count));
    tab_count  = 0;
    done_count = 0;
    now        = 0;
    sum_tat    = 0;
    sum_wt     = 0;
    ovf_seen   = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      srtf_load_and_run(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16], s_axis_tlast_i);
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= no_stall || ($urandom_range(99) >= IdlePct);
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sched_rec_t got;
    sched_rec_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind    = m_axis_tuser_o;
      got.idx     = m_axis_tdata_o[3:0];
      got.fin     = m_axis_tdata_o[24:4];
      got.tat     = m_axis_tdata_o[44:25];
      got.wt      = m_axis_tdata_o[64:45];
      got.sum_tat = m_axis_tdata_o[88:65];
      got.sum_wt  = m_axis_tdata_o[112:89];
      got.count   = m_axis_tdata_o[117:113];
      got.ovf     = m_axis_tdata_o[118];
      got.last    = m_axis_tlast_o;
      if (due_records.size() == 0) begin
        $display("%0t: beat expected none, got kind %0b idx %0d finish %0d", $time,
                 got.kind, got.idx, got.fin);
        errors++;
      end else begin
        want = due_records.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("proc_index", want.idx, got.idx);
        check_field("finish_time", want.fin, got.fin);
        check_field("turnaround", want.tat, got.tat);
        check_field("waiting", want.wt, got.wt);
        check_field("total_turnaround", want.sum_tat, got.sum_tat);
        check_field("total_waiting", want.sum_wt, got.sum_wt);
        check_field("process_count", want.count, got.count);
        check_field("overflow", want.ovf, got.ovf);
        check_field("last_result", want.last, got.last);
      end
    end
  end

  task automatic send_beat(input logic [15:0] arr, input logic [15:0] bur, input logic last);
    while (!no_stall && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {bur, arr};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (due_records.size() != 0);
  endtask

  task automatic send_random_set(input int unsigned n);
    int unsigned span;
    int unsigned k;
    int unsigned r;
    logic [15:0] arr;
    logic [15:0] bur;
    case ($urandom_range(3))
      0: span = 0;
      1: span = 15;
      2: span = 200;
      default: span = 65535;
    endcase
    for (k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      arr = 16'($urandom_range(span));
      if (r < 3) bur = '0;
      else if (r < 15) bur = 16'($urandom_range(65535));
      else bur = 16'($urandom_range(30, 1));
      send_beat(arr, bur, k == n - 1);
    end
  endtask

  task automatic test_single_zero_burst();
    send_beat(16'd0, 16'd0, 1'b1);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    send_beat(16'hFFFF, 16'hFFFF, 1'b0);
    send_beat(16'h0000, 16'hFFFF, 1'b0);
    send_beat(16'hFFFF, 16'h0000, 1'b0);
    send_beat(16'hAAAA, 16'h5555, 1'b0);
    send_beat(16'h5555, 16'hAAAA, 1'b1);
    wait_idle();
  endtask

  task automatic test_ties_and_preemption();
    send_beat(16'd3, 16'd5, 1'b0);
    send_beat(16'd3, 16'd5, 1'b0);
    send_beat(16'd0, 16'd9, 1'b1);
    send_beat(16'd10, 16'd1, 1'b0);
    send_beat(16'd40, 16'd2, 1'b1);
    wait_idle();
  endtask

  task automatic test_set_full();
    int unsigned k;
    for (k = 0; k < NProc + 1; k++)
      send_beat(16'($urandom_range(40)), 16'($urandom_range(12, 1)), k == NProc);
    wait_idle();
  endtask

  task automatic test_random_sets();
    int unsigned r;
    while (items_sent < ItemGoal) begin
      r = $urandom_range(99);
      if (r < 70) send_random_set($urandom_range(8, 1));
      else if (r < 85) send_random_set($urandom_range(15, 9));
      else if (r < 93) send_random_set(NProc);
      else send_random_set($urandom_range(NProc + 4, NProc + 1));
    end
    wait_idle();
  endtask

  task automatic test_back_to_back();
    int unsigned k;
    no_stall = 1'b1;
    for (k = 0; k < 6; k++) send_random_set($urandom_range(NProc, 1));
    wait_idle();
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_zero_burst();
    test_field_extremes();
    test_ties_and_preemption();
    test_set_full();
    test_back_to_back();
    test_random_sets();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
